// ===== rtl/ptca_pkg.sv =====
`timescale 1ns / 1ps

package ptca_pkg;

	localparam int PEER_SLOTS = 32;
	localparam int SLOT_W     = $clog2(PEER_SLOTS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_W      = 64;
	localparam int DIVR_W     = 32;

	localparam logic [63:0] MIN_DIST_Q  = 64'd655;
	localparam logic [63:0] MIN_DIST_SQ = MIN_DIST_Q * MIN_DIST_Q;

	localparam logic [7:0]  RST_NODE_ID  = 8'd0;
	localparam logic [15:0] RST_TIMEOUT  = 16'd1000;
	localparam logic [30:0] RST_MIN_SEP  = 31'd10945;
	localparam logic [30:0] RST_STEP     = 31'd19661;
	localparam logic [30:0] RST_CRUISE   = 31'd19661;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_ID   = 3'd0,
		REG_HOME_X    = 3'd1,
		REG_HOME_Y    = 3'd2,
		REG_TIMEOUT   = 3'd3,
		REG_MIN_SEP   = 3'd4,
		REG_STEP      = 3'd5,
		REG_CRUISE    = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PKT_CHK,
		ST_SCAN,
		ST_TRIG,
		ST_SQRT,
		ST_MUL,
		ST_DIVGO,
		ST_DIV,
		ST_ADD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [7:0]  seq;
		logic [31:0] seen;
	} entry_t;

	function automatic logic [31:0] sat35(input logic [34:0] v);
		logic [31:0] r;
		if (v[34:31] != 4'b0000 && v[34:31] != 4'b1111) begin
			r = v[34] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] abs33(input logic [32:0] v);
		logic [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

endpackage

// ===== rtl/ptca_if.sv =====
`timescale 1ns / 1ps

interface ptca_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  peer_id;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [7:0]  detection;
	logic [7:0]  seq_num;
	logic [31:0] now_ms;
	logic        is_flying;
	modport source (output valid, action, peer_id, pos_x, pos_y, pos_z, detection, seq_num,
		now_ms, is_flying, input ready);
	modport sink (input valid, action, peer_id, pos_x, pos_y, pos_z, detection, seq_num,
		now_ms, is_flying, output ready);
endinterface

interface ptca_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] tx_x;
	logic [31:0] tx_y;
	logic [31:0] tx_z;
	logic [7:0]  tx_detection;
	logic [7:0]  tx_seq;
	logic        move_valid;
	logic [31:0] move_x;
	logic [31:0] move_y;
	logic [31:0] move_z;
	logic        move_suppressed;
	modport source (output valid, tx_x, tx_y, tx_z, tx_detection, tx_seq, move_valid, move_x,
		move_y, move_z, move_suppressed, input ready);
	modport sink (input valid, tx_x, tx_y, tx_z, tx_detection, tx_seq, move_valid, move_x,
		move_y, move_z, move_suppressed, output ready);
endinterface

interface ptca_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/peer_table_collision_avoid_unit.sv =====
`timescale 1ns / 1ps

// Peer table for swarm collision avoidance.
// Channels: req carries items (action 0 peer packet, action 1 control cycle), rsp carries
// one result per control item, cfg writes the seven configuration registers (ready is
// always high; write only while the block is idle).
// A peer packet reads the table on accept, then compares and writes back; it gives no result.
// A control item reads every peer slot from the table memory, one slot per cycle, through a
// pipelined distance computation. When a move is due and the node flies, a 32-step square
// root and a 64-step divider per axis follow. req is ready only while no item is in work.
// The result goes to an output register; the next item is accepted while it waits, and a
// control item that finishes while the previous result is still stalled holds until rsp
// takes it. Reset clears the active flags, the sequence counter and the output valid, and
// loads the register defaults; the table is not reset, and active flags mask unwritten slots.
module peer_table_collision_avoid_unit (
	input logic        clk,
	input logic        arst_n,
	ptca_cfg_if.sink   cfg,
	ptca_req_if.sink   req,
	ptca_rsp_if.source rsp
);
	import ptca_pkg::*;

	localparam logic [8:0]        SLOTS_9  = 9'(PEER_SLOTS);
	localparam logic [SLOT_W:0]   SLOTS_SW = (SLOT_W + 1)'(PEER_SLOTS);

	state_t state_q, state_d;

	logic [7:0]  node_id_q;
	logic [31:0] hox_q, hoy_q;
	logic [15:0] timeout_q;
	logic [30:0] min_sep_q, step_q, cruise_q;
	logic [61:0] ms_sq_q;

	logic [31:0]       px_q, py_q, pz_q, now_q, gx_q, gy_q;
	logic [7:0]        det_q, seq_in_q, txseq_q, txc_q;
	logic              fly_q;
	logic [SLOT_W-1:0] pid_q;

	logic [PEER_SLOTS-1:0] active_q;
	logic [SLOT_W:0]       scan_idx_q;

	logic              v_s1, v_s2, v_s3;
	logic [SLOT_W-1:0] idx_s1;
	logic [32:0]       dx_s2, dy_s2, dz_s2, ax_s3, ay_s3;
	logic              high_s2, high_s3;
	logic [63:0]       sqx_s3, sqy_s3, sqz_s3;

	logic        found_q, high_q;
	logic [63:0] best_q, bsqx_q, bsqy_q;
	logic [32:0] bax_q, bay_q;

	logic [63:0] sq_v_q;
	logic [32:0] sq_rem_q;
	logic [31:0] sq_root_q;
	logic [4:0]  sq_cnt_q;

	logic [63:0] prodx_q, prody_q;
	logic        mv_q, supp_q;
	logic [31:0] mx_q, my_q;
	logic        out_vld_q;

	logic              acc, pkt_ok, scan_issue, scan_done, mem_we, div_start, out_load;
	logic              trig, aged, live;
	logic [SLOT_W-1:0] mem_raddr;
	logic [$bits(entry_t)-1:0] mem_rdata;
	entry_t            rd, wr;
	logic [31:0]       age;
	logic [64:0]       h2;
	logic [65:0]       d2_sum;
	logic [63:0]       d2;
	logic [34:0]       rem_sh, trial, rem_sub;
	logic              div_done_x, div_done_y;
	logic [63:0]       quot_x, quot_y;
	logic [34:0]       gx_sum, gy_sum, mx_sum, my_sum, qx_sgn, qy_sgn;

	ptca_ram #(.WIDTH($bits(entry_t)), .DEPTH(PEER_SLOTS)) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (pid_q),
		.wdata (wr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ptca_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prodx_q + {33'b0, sq_root_q[31:1]}),
		.divisor  (sq_root_q),
		.done     (div_done_x),
		.quotient (quot_x)
	);

	ptca_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prody_q + {33'b0, sq_root_q[31:1]}),
		.divisor  (sq_root_q),
		.done     (div_done_y),
		.quotient (quot_y)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= RST_NODE_ID;
			hox_q     <= '0;
			hoy_q     <= '0;
			timeout_q <= RST_TIMEOUT;
			min_sep_q <= RST_MIN_SEP;
			step_q    <= RST_STEP;
			cruise_q  <= RST_CRUISE;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_NODE_ID: node_id_q <= cfg.data[7:0];
				REG_HOME_X:  hox_q     <= cfg.data;
				REG_HOME_Y:  hoy_q     <= cfg.data;
				REG_TIMEOUT: timeout_q <= cfg.data[15:0];
				REG_MIN_SEP: min_sep_q <= cfg.data[30:0];
				REG_STEP:    step_q    <= cfg.data[30:0];
				REG_CRUISE:  cruise_q  <= cfg.data[30:0];
				default: ;
			endcase
		end
	end

	assign acc    = req.valid && req.ready;
	assign pkt_ok = ({1'b0, req.peer_id} < SLOTS_9) && (req.peer_id != node_id_q);

	assign rd  = entry_t'(mem_rdata);
	assign wr  = '{x: px_q, y: py_q, z: pz_q, seq: seq_in_q, seen: now_q};
	assign age = now_q - rd.seen;
	assign aged = age > {16'b0, timeout_q};
	assign live = active_q[idx_s1] && !aged;

	assign d2_sum = {2'b0, sqx_s3} + {2'b0, sqy_s3} + {2'b0, sqz_s3};
	assign d2     = (d2_sum[65:64] != 2'b00) ? '1 : d2_sum[63:0];

	assign h2   = {1'b0, bsqx_q} + {1'b0, bsqy_q};
	assign trig = found_q && (best_q < {2'b0, ms_sq_q}) && (best_q > MIN_DIST_SQ)
		&& ($signed(pz_q) > $signed({1'b0, cruise_q})) && high_q && (h2 > {1'b0, MIN_DIST_SQ});

	assign rem_sh  = {sq_rem_q, sq_v_q[63:62]};
	assign trial   = {1'b0, sq_root_q, 2'b01};
	assign rem_sub = rem_sh - trial;

	assign scan_done = (scan_idx_q == SLOTS_SW) && !v_s1 && !v_s2 && !v_s3;

	assign gx_sum = {{3{req.pos_x[31]}}, req.pos_x} + {{3{hox_q[31]}}, hox_q};
	assign gy_sum = {{3{req.pos_y[31]}}, req.pos_y} + {{3{hoy_q[31]}}, hoy_q};
	assign qx_sgn = bax_q[32] ? -{2'b0, quot_x[32:0]} : {2'b0, quot_x[32:0]};
	assign qy_sgn = bay_q[32] ? -{2'b0, quot_y[32:0]} : {2'b0, quot_y[32:0]};
	assign mx_sum = {{3{px_q[31]}}, px_q} + qx_sgn;
	assign my_sum = {{3{py_q[31]}}, py_q} + qy_sgn;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (req.action) begin
						state_d = ST_SCAN;
					end else if (pkt_ok) begin
						state_d = ST_PKT_CHK;
					end
				end
			end
			ST_PKT_CHK: state_d = ST_IDLE;
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_TRIG;
				end
			end
			ST_TRIG: state_d = (trig && fly_q) ? ST_SQRT : ST_FINISH;
			ST_SQRT: begin
				if (sq_cnt_q == '0) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_DIVGO;
			ST_DIVGO: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done_x && div_done_y) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: state_d = ST_FINISH;
			ST_FINISH: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready  = 1'b0;
		mem_raddr  = scan_idx_q[SLOT_W-1:0];
		scan_issue = 1'b0;
		mem_we     = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				mem_raddr = req.peer_id[SLOT_W-1:0];
			end
			ST_PKT_CHK: mem_we = !(active_q[pid_q] && rd.seq == seq_in_q);
			ST_SCAN:    scan_issue = scan_idx_q < SLOTS_SW;
			ST_DIVGO:   div_start = 1'b1;
			ST_FINISH:  out_load = !out_vld_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			active_q   <= '0;
			txc_q      <= '0;
			out_vld_q  <= 1'b0;
			scan_idx_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			found_q    <= 1'b0;
			high_q     <= 1'b0;
			sq_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc && req.action) begin
				txc_q      <= txc_q + 8'd1;
				scan_idx_q <= '0;
				found_q    <= 1'b0;
				high_q     <= 1'b0;
			end
			if (scan_issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (mem_we) begin
				active_q[pid_q] <= 1'b1;
			end
			if (v_s1 && active_q[idx_s1] && aged) begin
				active_q[idx_s1] <= 1'b0;
			end
			v_s1 <= scan_issue;
			v_s2 <= v_s1 && live;
			v_s3 <= v_s2;
			if (v_s3) begin
				high_q <= high_q | high_s3;
				if (!found_q || d2 < best_q) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == ST_TRIG) begin
				sq_cnt_q <= 5'd31;
			end else if (state_q == ST_SQRT) begin
				sq_cnt_q <= sq_cnt_q - 5'd1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ms_sq_q <= min_sep_q * min_sep_q;
		if (acc) begin
			px_q     <= req.pos_x;
			py_q     <= req.pos_y;
			pz_q     <= req.pos_z;
			det_q    <= req.detection;
			seq_in_q <= req.seq_num;
			now_q    <= req.now_ms;
			fly_q    <= req.is_flying;
			pid_q    <= req.peer_id[SLOT_W-1:0];
			gx_q     <= sat35(gx_sum);
			gy_q     <= sat35(gy_sum);
			txseq_q  <= txc_q;
		end
		idx_s1  <= mem_raddr;
		dx_s2   <= {gx_q[31], gx_q} - {rd.x[31], rd.x};
		dy_s2   <= {gy_q[31], gy_q} - {rd.y[31], rd.y};
		dz_s2   <= {pz_q[31], pz_q} - {rd.z[31], rd.z};
		high_s2 <= $signed(rd.z) > $signed({1'b0, cruise_q});
		sqx_s3  <= abs33(dx_s2) * abs33(dx_s2);
		sqy_s3  <= abs33(dy_s2) * abs33(dy_s2);
		sqz_s3  <= abs33(dz_s2) * abs33(dz_s2);
		ax_s3   <= dx_s2;
		ay_s3   <= dy_s2;
		high_s3 <= high_s2;
		if (v_s3 && (!found_q || d2 < best_q)) begin
			best_q <= d2;
			bsqx_q <= sqx_s3;
			bsqy_q <= sqy_s3;
			bax_q  <= ax_s3;
			bay_q  <= ay_s3;
		end
		if (state_q == ST_TRIG) begin
			mv_q      <= trig && fly_q;
			supp_q    <= trig && !fly_q;
			sq_v_q    <= h2[63:0];
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end
		if (state_q == ST_SQRT) begin
			sq_v_q <= {sq_v_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				sq_rem_q  <= rem_sub[32:0];
				sq_root_q <= {sq_root_q[30:0], 1'b1};
			end else begin
				sq_rem_q  <= rem_sh[32:0];
				sq_root_q <= {sq_root_q[30:0], 1'b0};
			end
		end
		if (state_q == ST_MUL) begin
			prodx_q <= abs33(bax_q) * {1'b0, step_q};
			prody_q <= abs33(bay_q) * {1'b0, step_q};
		end
		if (state_q == ST_ADD) begin
			mx_q <= sat35(mx_sum);
			my_q <= sat35(my_sum);
		end
		if (out_load) begin
			rsp.tx_x            <= gx_q;
			rsp.tx_y            <= gy_q;
			rsp.tx_z            <= pz_q;
			rsp.tx_detection    <= det_q;
			rsp.tx_seq          <= txseq_q;
			rsp.move_valid      <= mv_q;
			rsp.move_x          <= mv_q ? mx_q : '0;
			rsp.move_y          <= mv_q ? my_q : '0;
			rsp.move_z          <= mv_q ? pz_q : '0;
			rsp.move_suppressed <= supp_q;
		end
	end

	assign rsp.valid = out_vld_q;

	a_move_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.move_valid && rsp.move_suppressed))
		else $error("move and suppressed flags both set");

	a_pkt_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && !req.action) |=> !$rose(rsp.valid))
		else $error("peer packet produced a result");

	a_seq_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.action) |=> txc_q == $past(txc_q) + 8'd1)
		else $error("sequence counter did not advance");

endmodule

// ===== rtl/ptca_ram.sv =====
`timescale 1ns / 1ps

module ptca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/ptca_div.sv =====
`timescale 1ns / 1ps

module ptca_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ptca_pkg::DIV_W-1:0]  dividend,
	input  logic [ptca_pkg::DIVR_W-1:0] divisor,
	output logic                       done,
	output logic [ptca_pkg::DIV_W-1:0]  quotient
);
	import ptca_pkg::*;

	localparam int CW = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dsr_q;
	logic [DIVR_W:0]   rem_sh;
	logic [DIVR_W:0]   rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
